FILE: rtl/assert_macros.svh
// Assertion macros, used by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/avt_pkg.sv
// Types, codes and constants of the affine vertex transform.
`default_nettype none
package avt_pkg;
	localparam int MAX_ELEMENTS_DEF = 65536;
	localparam int COEFF_FRAC_DEF   = 12;
	localparam int FIFO_DEPTH       = 4;
	localparam int SUM_W            = 52;
	localparam int MAG_W            = 49;
	localparam int NORM_W           = 30;
	localparam int SQR_W            = 60;
	localparam int SQ_W             = 64;
	localparam int SQRT_STEPS       = 32;
	localparam int LEN_W            = 32;
	localparam int REM_W            = 48;
	localparam int QUO_W            = 17;

	localparam logic [63:0] ROW0_RST = 64'h0000_0000_0000_1000;
	localparam logic [63:0] ROW1_RST = 64'h0000_0000_1000_0000;
	localparam logic [63:0] ROW2_RST = 64'h0000_1000_0000_0000;

	typedef enum logic [2:0] {
		REG_ROW0,
		REG_ROW1,
		REG_ROW2,
		REG_START,
		REG_COUNT
	} reg_idx_t;

	localparam logic OP_POSITION = 1'b0;
	localparam logic OP_NORMAL   = 1'b1;

	localparam logic [1:0] ST_XFORM = 2'd0;
	localparam logic [1:0] ST_PASS  = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;
	localparam logic [1:0] ST_ZERO  = 2'd3;

	typedef logic [2:0][3:0][15:0] mat_t;

	typedef struct packed {
		logic               operation;
		logic [15:0]        elem_index;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [1:0]         status;
	} out_item_t;

	typedef struct packed {
		logic        op;
		logic        xform;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} q_item_t;

	typedef struct packed {
		logic      norm;
		logic [2:0] neg;
		out_item_t res;
	} hold_t;

	typedef struct packed {
		hold_t                  hold;
		logic [2:0][NORM_W-1:0] mag;
	} nside_t;
endpackage
`default_nettype wire

FILE: rtl/affine_vertex_transform_top.sv
// Affine vertex/normal transform, top level: front end, queue, arithmetic back end.
// Throughput: one item per cycle; the back end is a single lock-step pipeline (products,
// normalize, 32-stage square root, 17-stage divider) that halts only while a result waits.
// Reset (arst_n low): queue and pipeline empty, matrix identity, range covers all elements.
`default_nettype none
module affine_vertex_transform_top import avt_pkg::*; #(
	parameter int MAX_ELEMENTS    = MAX_ELEMENTS_DEF,
	parameter int COEFF_FRAC_BITS = COEFF_FRAC_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	// front to queue
	logic    push, full;
	q_item_t push_item;
	// queue to back end
	logic    pop, empty;
	q_item_t pop_item;
	// matrix from the configuration registers; the user must keep it stable while items are in flight (not enforced)
	mat_t    mat;

	// Front end: hold the registers, classify each item against the index range,
	// push it into the queue. It takes an item whenever the queue has room.
	avt_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.push_item(push_item),
		.full     (full),
		.mat      (mat)
	);

	// Queue: absorb the skew between a stalled back end and the front.
	avt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (full),
		.pop      (pop),
		.pop_item (pop_item),
		.empty    (empty)
	);

	// Back end: advance all stages together; positions and pass-through items
	// ride along the normal path so results leave in order.
	avt_back #(
		.COEFF_FRAC_BITS(COEFF_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mat      (mat),
		.empty    (empty),
		.pop_item (pop_item),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);
endmodule
`default_nettype wire

FILE: rtl/avt_front.sv
// Front end: configuration registers and range classification of items.
`default_nettype none
module avt_front import avt_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	output logic             push,
	output q_item_t          push_item,
	input  wire logic        full,
	output mat_t             mat
);
	localparam int RW = ($clog2(MAX_ELEMENTS) + 1 > 18) ? $clog2(MAX_ELEMENTS) + 1 : 18;

	mat_t        mat_q;
	logic [15:0] start_q;
	logic [16:0] count_q;
	logic [RW-1:0] start_w, sum_w, end_w, max_w, idx_w;

	assign cfg_ready = 1'b1;
	assign mat = mat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= ROW0_RST;
			mat_q[1] <= ROW1_RST;
			mat_q[2] <= ROW2_RST;
			start_q  <= '0;
			count_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW0:  mat_q[0] <= cfg_data;
				REG_ROW1:  mat_q[1] <= cfg_data;
				REG_ROW2:  mat_q[2] <= cfg_data;
				REG_START: start_q  <= cfg_data[15:0];
				REG_COUNT: count_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// end of range: start + count, clipped to the array size; zero count runs to the end
	assign start_w = RW'(start_q);
	assign sum_w   = RW'(start_q) + RW'(count_q);
	assign max_w   = RW'(MAX_ELEMENTS);
	assign idx_w   = RW'(in_data.elem_index);
	assign end_w   = (count_q != '0 && sum_w < max_w) ? sum_w : max_w;

	assign in_ready = !full;
	assign push     = in_valid && !full;

	always_comb begin
		push_item.op    = in_data.operation;
		push_item.xform = (start_w < max_w) && (idx_w >= start_w) && (idx_w < end_w);
		push_item.x     = in_data.coord_x;
		push_item.y     = in_data.coord_y;
		push_item.z     = in_data.coord_z;
	end
endmodule
`default_nettype wire

FILE: rtl/avt_fifo.sv
// Short queue between the front end and the arithmetic back end.
`default_nettype none
`include "assert_macros.svh"
module avt_fifo import avt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire q_item_t push_item,
	output logic         full,
	input  wire logic    pop,
	output q_item_t      pop_item,
	output logic         empty
);
	localparam int PW = $clog2(FIFO_DEPTH);

	q_item_t     mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full     = (cnt_q == (PW+1)'(FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_cnt_over, clk, arst_n, cnt_q > (PW+1)'(FIFO_DEPTH))
	`ASSERT_ALWAYS(a_ptr_cnt, clk, arst_n, (wr_q - rd_q) == cnt_q[PW-1:0])
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && empty)
endmodule
`default_nettype wire

FILE: rtl/avt_norm.sv
// Pipelined square root and three-lane divider for normal renormalization.
`default_nettype none
module avt_norm import avt_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic [SQ_W-1:0] in_sum,
	input  wire nside_t          in_side,
	output logic                 out_valid,
	output hold_t                out_hold,
	output logic [2:0][QUO_W-1:0] out_quo
);
	// square root stages, one result bit each
	logic [SQ_W-1:0] rt_rem_s [SQRT_STEPS];
	logic [SQ_W-1:0] rt_res_s [SQRT_STEPS];
	nside_t          rt_sd_s  [SQRT_STEPS];
	logic            rt_v_s   [SQRT_STEPS];

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (SQ_W - 2 - 2*i);
		logic [SQ_W-1:0] vi, ri, tr;
		nside_t          si;
		logic            vvi;
		if (i == 0) begin : g_first
			assign vi  = in_sum;
			assign ri  = '0;
			assign si  = in_side;
			assign vvi = in_valid;
		end else begin : g_next
			assign vi  = rt_rem_s[i-1];
			assign ri  = rt_res_s[i-1];
			assign si  = rt_sd_s[i-1];
			assign vvi = rt_v_s[i-1];
		end
		assign tr = ri + BITV;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[i] <= 1'b0;
			end else if (en) begin
				rt_v_s[i] <= vvi;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (vi >= tr) begin
					rt_rem_s[i] <= vi - tr;
					rt_res_s[i] <= (ri >> 1) + BITV;
				end else begin
					rt_rem_s[i] <= vi;
					rt_res_s[i] <= ri >> 1;
				end
				rt_sd_s[i] <= si;
			end
		end
	end

	// restoring divide, one quotient bit a stage, MSB first
	logic [2:0][REM_W-1:0] dv_rem_s [QUO_W];
	logic [2:0][QUO_W-1:0] dv_quo_s [QUO_W];
	logic [LEN_W-1:0]      dv_len_s [QUO_W];
	hold_t                 dv_hd_s  [QUO_W];
	logic                  dv_v_s   [QUO_W];

	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		logic [2:0][REM_W-1:0] remi;
		logic [2:0][QUO_W-1:0] quoi;
		logic [LEN_W-1:0]      leni;
		hold_t                 hdi;
		logic                  vvi;
		logic [REM_W-1:0]      dvs;
		if (j == 0) begin : g_first
			logic [LEN_W-1:0] len;
			assign len  = rt_res_s[SQRT_STEPS-1][LEN_W-1:0];
			assign leni = len;
			assign hdi  = rt_sd_s[SQRT_STEPS-1].hold;
			assign vvi  = rt_v_s[SQRT_STEPS-1];
			assign quoi = '0;
			for (genvar r = 0; r < 3; r++) begin : g_init
				// numerator: magnitude in Q16 plus half the length, for rounding
				assign remi[r] = {2'b00, rt_sd_s[SQRT_STEPS-1].mag[r], 16'h0000}
					+ REM_W'(len >> 1);
			end
		end else begin : g_next
			assign remi = dv_rem_s[j-1];
			assign quoi = dv_quo_s[j-1];
			assign leni = dv_len_s[j-1];
			assign hdi  = dv_hd_s[j-1];
			assign vvi  = dv_v_s[j-1];
		end
		assign dvs = REM_W'(leni) << (QUO_W - 1 - j);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (en) begin
				dv_v_s[j] <= vvi;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int r = 0; r < 3; r++) begin
					if (remi[r] >= dvs) begin
						dv_rem_s[j][r] <= remi[r] - dvs;
						dv_quo_s[j][r] <= {quoi[r][QUO_W-2:0], 1'b1};
					end else begin
						dv_rem_s[j][r] <= remi[r];
						dv_quo_s[j][r] <= {quoi[r][QUO_W-2:0], 1'b0};
					end
				end
				dv_len_s[j] <= leni;
				dv_hd_s[j]  <= hdi;
			end
		end
	end

	assign out_valid = dv_v_s[QUO_W-1];
	assign out_hold  = dv_hd_s[QUO_W-1];
	assign out_quo   = dv_quo_s[QUO_W-1];
endmodule
`default_nettype wire

FILE: rtl/avt_back.sv
// Back end: matrix products, rounding, saturation and normal scaling.
`default_nettype none
module avt_back import avt_pkg::*; #(
	parameter int COEFF_FRAC_BITS = COEFF_FRAC_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire mat_t    mat,
	input  wire logic    empty,
	input  wire q_item_t pop_item,
	output logic         pop,
	output logic         out_valid,
	input  wire logic    out_ready,
	output out_item_t    out_data
);
	localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (COEFF_FRAC_BITS - 1);

	logic en;
	logic out_v_q;
	out_item_t out_q;

	// the whole pipe moves as one; it halts only while a result waits
	assign en        = !out_v_q || out_ready;
	assign pop       = en && !empty;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// stage 1: nine products
	logic               v_s1;
	q_item_t            it_s1;
	logic signed [47:0] prod_s1 [3][3];
	logic [31:0]        crd [3];

	assign crd[0] = pop_item.x;
	assign crd[1] = pop_item.y;
	assign crd[2] = pop_item.z;

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= pop_item;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= 48'($signed(mat[r][c]) * $signed(crd[c]));
				end
			end
		end
	end

	// stage 2: row sums, translated and rounded sums
	logic                    v_s2;
	q_item_t                 it_s2;
	logic signed [SUM_W-1:0] s_s2  [3];
	logic signed [SUM_W-1:0] tp_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= it_s1;
			for (int r = 0; r < 3; r++) begin
				s_s2[r] <= SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1])
					+ SUM_W'(prod_s1[r][2]);
				tp_s2[r] <= SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1])
					+ SUM_W'(prod_s1[r][2])
					+ (SUM_W'($signed(mat[r][3])) <<< 16) + RND;
			end
		end
	end

	// stage 3: classify, finish positions and pass-through
	logic                    v_s3;
	hold_t                   hd_s3;
	logic [MAG_W-1:0]        mag_s3 [3];
	logic signed [SUM_W-1:0] sh [3];
	logic [31:0]             posv [3];
	logic [MAG_W-1:0]        magc [3];
	logic [2:0]              negc;
	logic                    sat;
	hold_t                   hdc;

	always_comb begin
		sat = 1'b0;
		for (int r = 0; r < 3; r++) begin
			sh[r] = tp_s2[r] >>> COEFF_FRAC_BITS;
			if (&sh[r][SUM_W-1:31] || ~|sh[r][SUM_W-1:31]) begin
				posv[r] = sh[r][31:0];
			end else begin
				sat     = 1'b1;
				posv[r] = sh[r][SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end
			negc[r] = s_s2[r][SUM_W-1];
			magc[r] = MAG_W'(negc[r] ? -s_s2[r] : s_s2[r]);
		end
		hdc.norm = 1'b0;
		hdc.neg  = negc;
		if (!it_s2.xform) begin
			hdc.res.out_x  = it_s2.x;
			hdc.res.out_y  = it_s2.y;
			hdc.res.out_z  = it_s2.z;
			hdc.res.status = ST_PASS;
		end else if (it_s2.op == OP_POSITION) begin
			hdc.res.out_x  = posv[0];
			hdc.res.out_y  = posv[1];
			hdc.res.out_z  = posv[2];
			hdc.res.status = sat ? ST_SAT : ST_XFORM;
		end else begin
			hdc.res.out_x  = '0;
			hdc.res.out_y  = '0;
			hdc.res.out_z  = '0;
			if (magc[0] == '0 && magc[1] == '0 && magc[2] == '0) begin
				hdc.res.status = ST_ZERO;
			end else begin
				hdc.res.status = ST_XFORM;
				hdc.norm       = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hd_s3 <= hdc;
			for (int r = 0; r < 3; r++) begin
				mag_s3[r] <= magc[r];
			end
		end
	end

	// stage 4: largest magnitude
	logic             v_s4;
	hold_t            hd_s4;
	logic [MAG_W-1:0] mag_s4 [3];
	logic [MAG_W-1:0] mx_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			hd_s4 <= hd_s3;
			for (int r = 0; r < 3; r++) begin
				mag_s4[r] <= mag_s3[r];
			end
			if (mag_s3[0] >= mag_s3[1] && mag_s3[0] >= mag_s3[2]) begin
				mx_s4 <= mag_s3[0];
			end else if (mag_s3[1] >= mag_s3[2]) begin
				mx_s4 <= mag_s3[1];
			end else begin
				mx_s4 <= mag_s3[2];
			end
		end
	end

	// stages 5 and 6: shift left until the largest magnitude tops bit 63
	logic        v_s5;
	hold_t       hd_s5;
	logic [63:0] w_s5 [3];
	logic [63:0] mx_s5;
	logic [63:0] wa [3];
	logic [63:0] wma;

	always_comb begin
		wma = 64'(mx_s4);
		for (int r = 0; r < 3; r++) begin
			wa[r] = 64'(mag_s4[r]);
		end
		if (wma[63:32] == '0) begin
			wma = wma << 32;
			for (int r = 0; r < 3; r++) wa[r] = wa[r] << 32;
		end
		if (wma[63:48] == '0) begin
			wma = wma << 16;
			for (int r = 0; r < 3; r++) wa[r] = wa[r] << 16;
		end
		if (wma[63:56] == '0) begin
			wma = wma << 8;
			for (int r = 0; r < 3; r++) wa[r] = wa[r] << 8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hd_s5 <= hd_s4;
			mx_s5 <= wma;
			for (int r = 0; r < 3; r++) w_s5[r] <= wa[r];
		end
	end

	logic              v_s6;
	hold_t             hd_s6;
	logic [NORM_W-1:0] m_s6 [3];
	logic [63:0]       wb [3];
	logic [63:0]       wmb;

	always_comb begin
		wmb = mx_s5;
		for (int r = 0; r < 3; r++) wb[r] = w_s5[r];
		if (wmb[63:60] == '0) begin
			wmb = wmb << 4;
			for (int r = 0; r < 3; r++) wb[r] = wb[r] << 4;
		end
		if (wmb[63:62] == '0) begin
			wmb = wmb << 2;
			for (int r = 0; r < 3; r++) wb[r] = wb[r] << 2;
		end
		if (!wmb[63]) begin
			wmb = wmb << 1;
			for (int r = 0; r < 3; r++) wb[r] = wb[r] << 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hd_s6 <= hd_s5;
			// keep the top bits: largest magnitude lands in [2^29, 2^30)
			for (int r = 0; r < 3; r++) m_s6[r] <= wb[r][63 -: NORM_W];
		end
	end

	// stage 7: squares; stage 8: sum of squares
	logic              v_s7, v_s8;
	hold_t             hd_s7;
	logic [NORM_W-1:0] m_s7 [3];
	logic [SQR_W-1:0]  sq_s7 [3];
	nside_t            sd_s8;
	logic [SQR_W+1:0]  sum_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			hd_s7 <= hd_s6;
			for (int r = 0; r < 3; r++) begin
				m_s7[r]  <= m_s6[r];
				sq_s7[r] <= SQR_W'(m_s6[r]) * SQR_W'(m_s6[r]);
			end
			sd_s8.hold <= hd_s7;
			for (int r = 0; r < 3; r++) sd_s8.mag[r] <= m_s7[r];
			sum_s8 <= (SQR_W+2)'(sq_s7[0]) + (SQR_W+2)'(sq_s7[1]) + (SQR_W+2)'(sq_s7[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= !empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	logic                  nv;
	hold_t                 nhd;
	logic [2:0][QUO_W-1:0] nquo;

	avt_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.in_sum   (SQ_W'(sum_s8)),
		.in_side  (sd_s8),
		.out_valid(nv),
		.out_hold (nhd),
		.out_quo  (nquo)
	);

	// apply signs to the scaled normal and load the output register
	out_item_t fin;
	logic [31:0] qv [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			qv[r] = nhd.neg[r] ? -(32'(nquo[r])) : 32'(nquo[r]);
		end
		fin = nhd.res;
		if (nhd.norm) begin
			fin.out_x = qv[0];
			fin.out_y = qv[1];
			fin.out_z = qv[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= nv;
		end
	end
endmodule
`default_nettype wire

FILE: tb/sv/affine_vertex_transform_top_tb.sv
// Self-checking testbench for the affine vertex and normal transform.
`timescale 1ns / 1ps
`default_nettype none
module affine_vertex_transform_top_tb;
	import avt_pkg::*;

	localparam int MAX_ELEM   = MAX_ELEMENTS_DEF;
	localparam int FRAC       = COEFF_FRAC_DEF;
	localparam int LATENCY    = 58;
	localparam int N_RANDOM   = 1330;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	affine_vertex_transform_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the configuration registers, kept in step with every write.
	logic [63:0] mat_row [3];
	logic [15:0] win_start;
	logic [16:0] win_count;

	out_item_t   expected_q [$];
	int          errors;
	int          n_results;
	int          n_xform, n_pass, n_sat, n_zero;
	int          send_idle_pct;
	int          recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs; far beyond the slowest legal run.
	initial begin
		#20ms;
		$display("FAIL affine_vertex_transform_top");
		$finish;
	end

	function automatic longint coeff(logic [63:0] row, int col);
		logic signed [15:0] c;
		c = row[16*col +: 16];
		return longint'(c);
	endfunction

	function automatic longint floor_sh(longint t, int k);
		return t >>> k;
	endfunction

	function automatic longint unsigned sqrt_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Compute the transformed vertex or normal under the current shadow config.
	function automatic out_item_t transform_vertex(in_item_t it);
		out_item_t       res;
		longint          v [3];
		longint          s [3];
		longint          t;
		longint unsigned mag [3];
		longint unsigned mx, sum, len, q;
		logic            neg [3];
		int              win_end;
		logic [31:0]     o [3];

		v[0] = longint'(it.coord_x);
		v[1] = longint'(it.coord_y);
		v[2] = longint'(it.coord_z);
		win_end = MAX_ELEM;
		if (win_count != 0 && int'(win_start) + int'(win_count) < win_end)
			win_end = int'(win_start) + int'(win_count);
		if (!(int'(win_start) < MAX_ELEM && it.elem_index >= win_start
				&& int'(it.elem_index) < win_end)) begin
			res.out_x = it.coord_x;
			res.out_y = it.coord_y;
			res.out_z = it.coord_z;
			res.status = ST_PASS;
			return res;
		end
		for (int r = 0; r < 3; r++) begin
			s[r] = 0;
			for (int c = 0; c < 3; c++)
				s[r] += coeff(mat_row[r], c) * v[c];
		end
		res.status = ST_XFORM;
		if (it.operation == OP_POSITION) begin
			for (int r = 0; r < 3; r++) begin
				t = s[r] + coeff(mat_row[r], 3) * 65536;
				t = floor_sh(t + (64'sd1 <<< (FRAC - 1)), FRAC);
				if (t > 64'sd2147483647) begin
					t = 64'sd2147483647;
					res.status = ST_SAT;
				end
				if (t < -64'sd2147483648) begin
					t = -64'sd2147483648;
					res.status = ST_SAT;
				end
				o[r] = t[31:0];
			end
		end else begin
			mx = 0;
			for (int r = 0; r < 3; r++) begin
				neg[r] = s[r] < 0;
				mag[r] = neg[r] ? longint'(-s[r]) : longint'(s[r]);
				if (mag[r] > mx) mx = mag[r];
			end
			if (mx == 0) begin
				res.out_x = '0;
				res.out_y = '0;
				res.out_z = '0;
				res.status = ST_ZERO;
				return res;
			end
			while (mx >= (64'd1 << 30)) begin
				mx >>= 1;
				for (int r = 0; r < 3; r++) mag[r] >>= 1;
			end
			while (mx < (64'd1 << 29)) begin
				mx <<= 1;
				for (int r = 0; r < 3; r++) mag[r] <<= 1;
			end
			sum = 0;
			for (int r = 0; r < 3; r++) sum += mag[r] * mag[r];
			len = sqrt_floor(sum);
			for (int r = 0; r < 3; r++) begin
				q = (mag[r] * 65536 + (len >> 1)) / len;
				t = neg[r] ? -longint'(q) : longint'(q);
				o[r] = t[31:0];
			end
		end
		if (res.status != ST_ZERO) begin
			res.out_x = o[0];
			res.out_y = o[1];
			res.out_z = o[2];
		end
		return res;
	endfunction

	// Write one register and mirror it into the shadow copy.
	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ROW0:  mat_row[0] = val;
			REG_ROW1:  mat_row[1] = val;
			REG_ROW2:  mat_row[2] = val;
			REG_START: win_start = val[15:0];
			REG_COUNT: win_count = val[16:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2);
		write_reg(REG_ROW0, r0);
		write_reg(REG_ROW1, r1);
		write_reg(REG_ROW2, r2);
	endtask

	// Drop valid, then drain the pipeline before touching configuration.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Offer one item; the prediction is queued at the accepting edge.
	// Valid stays high into the next item unless the sender idles first.
	task automatic send_vertex(in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(transform_vertex(it));
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(32'h0002_0000);
			3: return -$urandom_range(32'h0002_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] rand_row();
		logic [63:0] r;
		r = {$urandom, $urandom};
		if ($urandom_range(2) == 0)
			for (int c = 0; c < 4; c++)
				r[16*c +: 16] = 16'($signed($urandom_range(8192)) - 4096);
		return r;
	endfunction

	// Receiver: stall at random, check every result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result with nothing expected: %h", out_data);
					errors++;
				end else begin
					out_item_t e;
					e = expected_q.pop_front();
					n_results++;
					case (e.status)
						ST_XFORM: n_xform++;
						ST_PASS:  n_pass++;
						ST_SAT:   n_sat++;
						default:  n_zero++;
					endcase
					if (out_data.out_x !== e.out_x) begin
						$error("out_x expected %h actual %h", e.out_x, out_data.out_x);
						errors++;
					end
					if (out_data.out_y !== e.out_y) begin
						$error("out_y expected %h actual %h", e.out_y, out_data.out_y);
						errors++;
					end
					if (out_data.out_z !== e.out_z) begin
						$error("out_z expected %h actual %h", e.out_z, out_data.out_z);
						errors++;
					end
					if (out_data.status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, out_data.status);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	typedef struct {
		in_item_t    item;
		logic        check_typed;
		out_item_t   typed_result;
	} vec_row_t;

	vec_row_t    vectors [$];
	in_item_t    it;

	function automatic in_item_t mk(logic op, logic [15:0] idx, logic [31:0] x,
			logic [31:0] y, logic [31:0] z);
		in_item_t r;
		r.operation = op;
		r.elem_index = idx;
		r.coord_x = x;
		r.coord_y = y;
		r.coord_z = z;
		return r;
	endfunction

	function automatic out_item_t mo(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [1:0] st);
		out_item_t r;
		r.out_x = x;
		r.out_y = y;
		r.out_z = z;
		r.status = st;
		return r;
	endfunction

	initial begin
		errors = 0;
		n_results = 0;
		n_xform = 0; n_pass = 0; n_sat = 0; n_zero = 0;
		send_idle_pct = 8;
		recv_idle_pct = 85;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ROW0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		mat_row[0] = ROW0_RST;
		mat_row[1] = ROW1_RST;
		mat_row[2] = ROW2_RST;
		win_start = '0;
		win_count = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: identity after reset, extremes, zero normal, then axis and extreme normals.
		vectors.push_back('{mk(OP_POSITION, 16'd0, 32'h0001_0000, 32'hFFFF_0000, 32'd5),
			1'b1, mo(32'h0001_0000, 32'hFFFF_0000, 32'd5, ST_XFORM)});
		vectors.push_back('{mk(OP_POSITION, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF), 1'b1, mo(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, ST_XFORM)});
		vectors.push_back('{mk(OP_NORMAL, 16'd7, 32'd0, 32'd0, 32'd0),
			1'b1, mo(32'd0, 32'd0, 32'd0, ST_ZERO)});
		vectors.push_back('{mk(OP_NORMAL, 16'd1, 32'h0003_0000, 32'd0, 32'd0),
			1'b1, mo(32'h0001_0000, 32'd0, 32'd0, ST_XFORM)});
		vectors.push_back('{mk(OP_NORMAL, 16'd2, 32'd0, 32'h8000_0000, 32'd0),
			1'b1, mo(32'd0, 32'hFFFF_0000, 32'd0, ST_XFORM)});
		vectors.push_back('{mk(OP_NORMAL, 16'd3, 32'd1, 32'd1, 32'hFFFF_FFFF), 1'b0, '0});
		vectors.push_back('{mk(OP_NORMAL, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000), 1'b0, '0});
		foreach (vectors[i]) begin
			if (vectors[i].check_typed
					&& transform_vertex(vectors[i].item) !== vectors[i].typed_result) begin
				$error("table row %0d disagrees with prediction", i);
				errors++;
			end
			send_vertex(vectors[i].item);
		end
		wait_idle();

		// Scale by 8 (z by -8) with full translation: positions saturate both ways.
		load_matrix(64'h7FFF_0000_0000_7FFF, 64'h8000_0000_7FFF_0000,
			64'h7FFF_8000_0000_0000);
		send_vertex(mk(OP_POSITION, 16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		send_vertex(mk(OP_POSITION, 16'd9, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
		send_vertex(mk(OP_POSITION, 16'd9, 32'd0, 32'd0, 32'd0));
		send_vertex(mk(OP_NORMAL, 16'd10, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		send_vertex(mk(OP_NORMAL, 16'd10, 32'd1, 32'd0, 32'd0));
		wait_idle();

		// Window 100..103: check the edges on both sides.
		write_reg(REG_START, 64'd100);
		write_reg(REG_COUNT, 64'd4);
		send_vertex(mk(OP_POSITION, 16'd99, 32'd1, 32'd2, 32'd3));
		send_vertex(mk(OP_POSITION, 16'd100, 32'd1, 32'd2, 32'd3));
		send_vertex(mk(OP_NORMAL, 16'd103, 32'd1, 32'd2, 32'd3));
		send_vertex(mk(OP_NORMAL, 16'd104, 32'd1, 32'd2, 32'd3));
		wait_idle();
		// Largest start with largest count: window clamps at the end of the array.
		write_reg(REG_START, 64'hFFFF);
		write_reg(REG_COUNT, 64'h1_0000);
		send_vertex(mk(OP_POSITION, 16'hFFFE, 32'd4, 32'd5, 32'd6));
		send_vertex(mk(OP_POSITION, 16'hFFFF, 32'd4, 32'd5, 32'd6));
		wait_idle();
		// Zero matrix over the whole array: a zero normal and a zero position.
		write_reg(REG_START, 64'd0);
		write_reg(REG_COUNT, 64'd0);
		load_matrix(64'h0, 64'h0, 64'h0);
		send_vertex(mk(OP_NORMAL, 16'd0, 32'h1234_5678, 32'd1, 32'd2));
		send_vertex(mk(OP_POSITION, 16'd0, 32'h1234_5678, 32'd1, 32'd2));
		wait_idle();

		// Random phases: each sets a fresh matrix and window, then streams items.
		for (int n = 0; n < N_RANDOM; ) begin
			int burst;
			if (n >= N_RANDOM / 3 && send_idle_pct == 8) begin
				send_idle_pct = 85;
				recv_idle_pct = 8;
			end else if (n >= 2 * N_RANDOM / 3 && send_idle_pct == 85) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			load_matrix(rand_row(), rand_row(), rand_row());
			case ($urandom_range(3))
				0: begin
					write_reg(REG_START, 64'd0);
					write_reg(REG_COUNT, 64'd0);
				end
				1: begin
					write_reg(REG_START, $urandom_range(64));
					write_reg(REG_COUNT, $urandom_range(1, 64));
				end
				default: begin
					write_reg(REG_START, $urandom_range(16'hFFFF));
					write_reg(REG_COUNT, $urandom_range(17'h1_0000));
				end
			endcase
			burst = $urandom_range(40, 120);
			for (int k = 0; k < burst; k++) begin
				it.operation = 1'($urandom_range(1));
				it.elem_index = ($urandom_range(1) == 0) ? 16'($urandom_range(16'hFFFF))
					: 16'(win_start + $urandom_range(80)) - 16'd8;
				it.coord_x = rand_coord();
				it.coord_y = rand_coord();
				it.coord_z = ($urandom_range(9) == 0) ? 32'd0 : rand_coord();
				send_vertex(it);
			end
			n += burst;
			wait_idle();
		end

		$display("Covered %0d results: %0d transformed, %0d passed, %0d saturated,",
			n_results, n_xform, n_pass, n_sat);
		$display("%0d zero normals, across random matrices and element windows.", n_zero);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("PASS affine_vertex_transform_top");
		end else begin
			$display("FAIL affine_vertex_transform_top");
		end
		$finish;
	end
endmodule
`default_nettype wire
